// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: hw/rtl/drpi_pkg.sv
// ----------------------------------------------------------------------------
// drpi_pkg
// Types and constants shared by the pose integrator and its CORDIC unit.
// ----------------------------------------------------------------------------
package drpi_pkg;

   localparam int PERIOD_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TRIG_W     = 32;
   localparam int ATAN_IDX_W = 5;
   localparam int ATAN_DEPTH = 24;

   // event types
   localparam logic REQ_IMU   = 1'b0;
   localparam logic REQ_WHEEL = 1'b1;

   // register indexes (byte address bit 2)
   localparam logic REG_IMU_PERIOD  = 1'b0;
   localparam logic REG_ODOM_PERIOD = 1'b1;

   localparam logic [PERIOD_W-1:0] IMU_PERIOD_RST  = 16'd655;
   localparam logic [PERIOD_W-1:0] ODOM_PERIOD_RST = 16'd3277;

   // CORDIC start vector: 1/gain in Q2.30
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

   // atan(2^-i), 2^32 units per turn
   localparam logic [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic               req_type;
      logic signed [23:0] angular_rate;
      logic signed [15:0] accel;
      logic signed [23:0] wheel_speed;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic signed [23:0] speed;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;  // 2^32 units per turn
   } cordic_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } cordic_rsp_type;

endpackage

// File: hw/rtl/drpi_cordic.sv
// ----------------------------------------------------------------------------
// drpi_cordic
// Iterative CORDIC rotator: one micro-rotation per cycle, cos/sin in Q2.30.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drpi_cordic #(
   parameter int ITERS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  drpi_pkg::cordic_req_type cordic_req,
   output drpi_pkg::cordic_rsp_type cordic_rsp
);
   import drpi_pkg::*;

   localparam int ITER_W = $clog2(ITERS);

   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0]       z_ff, z_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     flip_ff, flip_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic signed [TRIG_W-1:0] dx, dy;
   logic signed [31:0]       atan_val;
   logic                     flip_start;

   always_comb begin
      dx         = y_ff >>> iter_ff;
      dy         = x_ff >>> iter_ff;
      atan_val   = signed'(ATAN_TABLE[ATAN_IDX_W'(iter_ff)]);
      flip_start = cordic_req.angle[31] ^ cordic_req.angle[30];

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (cordic_req.start) begin
         // second and third quadrants are rotated by a half turn
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = signed'({cordic_req.angle[31] ^ flip_start, cordic_req.angle[30:0]});
         flip_in = flip_start;
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
   end

   assign cordic_rsp.done    = done_ff;
   assign cordic_rsp.cos_val = flip_ff ? -x_ff : x_ff;
   assign cordic_rsp.sin_val = flip_ff ? -y_ff : y_ff;

   `ASSERT_NEVER(a_start_while_busy, clock, reset, cordic_req.start && busy_ff)
   `ASSERT_PROP(a_done_ends_run, clock, reset, done_ff |-> !busy_ff)
   `ASSERT_PROP(a_run_needs_start, clock, reset, $rose(busy_ff) |-> $past(cordic_req.start))

endmodule

// File: hw/rtl/dead_reckoning_pose_integrator.sv
// ----------------------------------------------------------------------------
// dead_reckoning_pose_integrator
// Planar pose (x, y, heading) and speed advanced by one IMU or wheel event.
// ----------------------------------------------------------------------------
// Sequence: each request runs through the iterative CORDIC plus five passes through
//   the shared multiplier; no new request is accepted until its result is written,
//   and the final update waits while an earlier result is still held by rsp_stall.
// Reset: pose and speed cleared, periods back to 655 and 3277, no result pending.
// A result waits in an output register while the next request is accepted.
`include "assert_macros.svh"

module dead_reckoning_pose_integrator #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_ITERS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  drpi_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output drpi_pkg::rsp_payload_type           rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [drpi_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [drpi_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [drpi_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import drpi_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_TURN = 3'd1;
   localparam logic [2:0] S_MUL_DIST = 3'd2;
   localparam logic [2:0] S_CORDIC   = 3'd3;
   localparam logic [2:0] S_MUL_X    = 3'd4;
   localparam logic [2:0] S_MUL_Y    = 3'd5;
   localparam logic [2:0] S_MUL_ACC  = 3'd6;
   localparam logic [2:0] S_UPD      = 3'd7;

   localparam logic signed [63:0] HALF_8  = 64'sd128;
   localparam logic signed [63:0] HALF_16 = 64'sd32768;
   localparam logic signed [63:0] HALF_17 = 64'sd65536;
   localparam logic signed [63:0] HALF_38 = 64'sd137438953472;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if ((v[25:23] != 3'b000) && (v[25:23] != 3'b111)) begin
         r = v[25] ? 24'sh80_0000 : 24'sh7f_ffff;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   logic [2:0]                state_ff, state_in;
   logic [PERIOD_W-1:0]       imu_period_ff, imu_period_in;
   logic [PERIOD_W-1:0]       odom_period_ff, odom_period_in;
   logic signed [31:0]        x_ff, x_in, y_ff, y_in;
   logic [ANGLE_BITS-1:0]     heading_ff, heading_in;
   logic signed [23:0]        speed_ff, speed_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   req_payload_type           req_ff, req_in;
   logic [PERIOD_W-1:0]       per_ff, per_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [31:0]        d_ff, d_in;
   logic [ANGLE_BITS-1:0]     dth_ff, dth_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic signed [31:0]        mul_a, mul_b;
   logic signed [63:0]        mul_p;
   logic signed [63:0]        turn_r16, turn_r17, step_full, acc_full;
   logic [ANGLE_BITS-1:0]     mid_angle, heading_new;
   logic signed [31:0]        pos_sel, pos_sat;
   logic signed [32:0]        pos_sum;
   logic signed [25:0]        spd_sum;
   logic signed [23:0]        speed_new;
   logic                      is_wheel, out_free, csr_write;
   cordic_req_type            cordic_req;
   cordic_rsp_type            cordic_rsp;

   drpi_cordic #(
      .ITERS (CORDIC_ITERS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .cordic_req (cordic_req),
      .cordic_rsp (cordic_rsp)
   );

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_ODOM_PERIOD) ?
                      CSR_DATA_W'(odom_period_ff) : CSR_DATA_W'(imu_period_ff);

   always_comb begin
      imu_period_in  = imu_period_ff;
      odom_period_in = odom_period_ff;
      if (csr_write) begin
         if (paddr[2] == REG_ODOM_PERIOD) begin
            odom_period_in = pwdata[PERIOD_W-1:0];
         end else begin
            imu_period_in = pwdata[PERIOD_W-1:0];
         end
      end
   end

   // ---------------- shared multiplier ----------------
   always_comb begin
      mul_b = 32'(signed'({1'b0, per_ff}));
      case (state_ff)
         S_MUL_TURN: mul_a = 32'(req_ff.angular_rate);
         S_MUL_DIST: mul_a = is_wheel ? 32'(req_ff.wheel_speed) : 32'(speed_ff);
         S_MUL_X: begin
            mul_a = d_ff;
            mul_b = cordic_rsp.cos_val;
         end
         S_MUL_Y: begin
            mul_a = d_ff;
            mul_b = cordic_rsp.sin_val;
         end
         S_MUL_ACC:  mul_a = 32'(req_ff.accel);
         default:    mul_a = '0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // ---------------- datapath ----------------
   assign is_wheel   = (req_ff.req_type == REQ_WHEEL);
   assign turn_r16   = (prod_ff + HALF_16) >>> 16;
   assign turn_r17   = (prod_ff + HALF_17) >>> 17;
   assign step_full  = (prod_ff + HALF_38) >>> 38;
   assign acc_full   = (prod_ff + HALF_8) >>> 8;
   assign mid_angle  = heading_ff + (is_wheel ? turn_r17[ANGLE_BITS-1:0] : '0);

   assign pos_sel    = (state_ff == S_MUL_Y) ? x_ff : y_ff;
   assign pos_sum    = {pos_sel[31], pos_sel} + step_full[32:0];
   assign pos_sat    = sat32(pos_sum);

   assign spd_sum    = {{2{speed_ff[23]}}, speed_ff} + acc_full[25:0];
   assign speed_new  = is_wheel ? req_ff.wheel_speed : sat24(spd_sum);
   assign heading_new = heading_ff + dth_ff;

   assign cordic_req.start = (state_ff == S_MUL_DIST);
   assign cordic_req.angle = {mid_angle, {(32 - ANGLE_BITS){1'b0}}};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in       = state_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      heading_in     = heading_ff;
      speed_in       = speed_ff;
      req_in         = req_ff;
      per_in         = per_ff;
      prod_in        = prod_ff;
      d_in           = d_ff;
      dth_in         = dth_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               per_in   = (req_payload.req_type == REQ_WHEEL) ?
                          odom_period_ff : imu_period_ff;
               state_in = S_MUL_TURN;
            end
         end
         S_MUL_TURN: begin
            prod_in  = mul_p;
            state_in = S_MUL_DIST;
         end
         S_MUL_DIST: begin
            dth_in   = turn_r16[ANGLE_BITS-1:0];
            prod_in  = mul_p;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            // distance stays in prod_ff until the first trig multiply
            d_in = prod_ff[39:8];
            if (cordic_rsp.done) begin
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            prod_in  = mul_p;
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            x_in     = pos_sat;
            prod_in  = mul_p;
            state_in = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            y_in     = pos_sat;
            prod_in  = mul_p;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (out_free) begin
               heading_in             = heading_new;
               speed_in               = speed_new;
               rsp_payload_in.pos_x   = x_ff;
               rsp_payload_in.pos_y   = y_ff;
               rsp_payload_in.heading = 16'({heading_new, 16'b0} >> ANGLE_BITS);
               rsp_payload_in.speed   = speed_new;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         imu_period_ff  <= IMU_PERIOD_RST;
         odom_period_ff <= ODOM_PERIOD_RST;
         x_ff           <= '0;
         y_ff           <= '0;
         heading_ff     <= '0;
         speed_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         imu_period_ff  <= imu_period_in;
         odom_period_ff <= odom_period_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         heading_ff     <= heading_in;
         speed_ff       <= speed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      per_ff         <= per_in;
      prod_ff        <= prod_in;
      d_ff           <= d_in;
      dth_ff         <= dth_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_PROP(a_accept_starts, clock, reset, req_valid && !req_stall |=> state_ff == S_MUL_TURN)
   `ASSERT_PROP(a_rsp_from_update, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_UPD)
   `ASSERT_NEVER(a_done_outside_cordic, clock, reset, cordic_rsp.done && state_ff != S_CORDIC)
   `ASSERT_PROP(a_update_waits, clock, reset, state_ff == S_UPD && rsp_valid_ff && rsp_stall |=> state_ff == S_UPD)

endmodule
